// File: rtl/core/stt_pkg.sv
// Types and constants for the software timer table.
// Shared by stt_cell and software_timer_table; no dependencies.
package stt_pkg;

    localparam int SLOT_W = 4;
    localparam int TIME_W = 32;
    localparam int PER_W  = 16;
    localparam int WAIT_W = 8;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_ACT    = 3'd2;
    localparam logic [2:0] CMD_DEACT  = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_WAIT = 2'd2;

    localparam logic [0:0] REG_MAX_WAIT = 1'b0;
    localparam logic [WAIT_W-1:0] MAX_WAIT_RST = 8'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_SCAN,
        ST_WAITR
    } state_t;

    typedef struct packed {
        logic              add_en;
        logic              act_en;
        logic              deact_en;
        logic              rem_en;
        logic              fire_en;
        logic [SLOT_W-1:0] target;
        logic [TIME_W-1:0] now;
        logic [PER_W-1:0]  period;
        logic              one_shot;
    } ctrl_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } chain_t;

    typedef struct packed {
        logic             running;
        logic             expired;
        logic [PER_W-1:0] rem;
    } status_t;

endpackage

// File: rtl/core/stt_cell.sv
// One timer slot: marks, period and last fire time, plus its link in the
// free-slot search chain. Depends on stt_pkg.
module stt_cell #(
    parameter int IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  stt_pkg::ctrl_t   ctrl,
    input  stt_pkg::chain_t  chain_in,
    output stt_pkg::chain_t  chain_out,
    output stt_pkg::status_t status
);

    logic occ_reg, occ_next;
    logic per_run_reg, per_run_next;
    logic once_reg, once_next;
    logic paused_reg, paused_next;
    logic [stt_pkg::TIME_W-1:0] last_reg, last_next;
    logic [stt_pkg::PER_W-1:0]  period_reg, period_next;

    logic free, claim, sel, has;
    logic [stt_pkg::TIME_W-1:0] el;

    assign free  = !occ_reg && !paused_reg;
    assign claim = ctrl.add_en && free && !chain_in.found;
    assign sel   = (ctrl.target == stt_pkg::SLOT_W'(IDX));
    assign has   = occ_reg || paused_reg;

    assign chain_out.found = chain_in.found || free;
    assign chain_out.idx   = (!chain_in.found && free) ? stt_pkg::SLOT_W'(IDX) : chain_in.idx;

    assign el             = ctrl.now - last_reg;
    assign status.running = per_run_reg || once_reg;
    assign status.expired = el >= {{(stt_pkg::TIME_W-stt_pkg::PER_W){1'b0}}, period_reg};
    assign status.rem     = period_reg - el[stt_pkg::PER_W-1:0];

    always_comb begin
        occ_next     = occ_reg;
        per_run_next = per_run_reg;
        once_next    = once_reg;
        paused_next  = paused_reg;
        last_next    = last_reg;
        period_next  = period_reg;
        if (claim) begin
            occ_next     = 1'b1;
            paused_next  = 1'b0;
            once_next    = ctrl.one_shot;
            per_run_next = !ctrl.one_shot;
            last_next    = ctrl.now;
            period_next  = ctrl.period;
        end
        if (ctrl.act_en && sel && has) begin
            occ_next     = 1'b1;
            paused_next  = 1'b0;
            per_run_next = 1'b1;
            last_next    = ctrl.now;
        end
        if (ctrl.deact_en && sel && has) begin
            occ_next     = 1'b0;
            paused_next  = 1'b1;
            per_run_next = 1'b0;
        end
        if ((ctrl.rem_en && sel) || (ctrl.fire_en && sel && once_reg)) begin
            occ_next     = 1'b0;
            paused_next  = 1'b0;
            per_run_next = 1'b0;
            once_next    = 1'b0;
        end
        if (ctrl.fire_en && sel) begin
            last_next = ctrl.now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= 1'b0;
            per_run_reg <= 1'b0;
            once_reg    <= 1'b0;
            paused_reg  <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            per_run_reg <= per_run_next;
            once_reg    <= once_next;
            paused_reg  <= paused_next;
        end
        last_reg   <= last_next;
        period_reg <= period_next;
    end

endmodule

// File: rtl/core/software_timer_table.sv
// Top level of the software timer table: command sequencer, slot chain,
// output register and APB register. Depends on stt_pkg and stt_cell.
//
// Each slot is a cell in a chain; add finds the lowest free slot through the
// chain in the cycle the command is taken. Add, activate, deactivate and
// remove are acknowledged through the output register; other codes but tick
// give no result. A tick scans one slot per cycle, over min(SLOTS,16) slots,
// unless a fire waits. Any result, fire, wait report or acknowledge, waits
// while the output register still holds an earlier transfer that m_tready
// has not taken, and each such cycle adds to the command's time. One item is
// processed at a time; s_tready is high only while the sequencer is idle,
// which may overlap the last result still waiting in the output register.
module software_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // now_secs[31:0], slot[35:32], period[51:36], one_shot[52]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_slot[3:0], ok[4], wait_secs[12:5]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NSLOT = (SLOTS < 16) ? SLOTS : 16;
    localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    stt_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [stt_pkg::WAIT_W-1:0] wait_reg, wait_next;
    logic [stt_pkg::WAIT_W-1:0] max_wait_reg;
    logic [stt_pkg::TIME_W-1:0] now_reg, now_next;
    logic [stt_pkg::SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic pend_ok_reg, pend_ok_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic [stt_pkg::TIME_W-1:0] in_now;
    logic [stt_pkg::SLOT_W-1:0] in_slot;
    logic [stt_pkg::PER_W-1:0]  in_period;
    logic in_once, accept, out_free, last_idx, slot_bad;

    stt_pkg::ctrl_t   ctrl;
    stt_pkg::chain_t  chain [0:NSLOT];
    stt_pkg::status_t stat  [0:NSLOT-1];
    stt_pkg::status_t cur;

    assign in_now    = s_tdata[31:0];
    assign in_slot   = s_tdata[35:32];
    assign in_period = s_tdata[51:36];
    assign in_once   = s_tdata[52];
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_idx  = (idx_reg == IW'(NSLOT - 1));
    assign slot_bad  = ({1'b0, in_slot} >= 5'(NSLOT));
    assign cur       = stat[idx_reg];

    assign chain[0] = '{found: 1'b0, idx: '0};

    for (genvar g = 0; g < NSLOT; g++) begin : g_cell
        stt_cell #(.IDX(g)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .chain_in (chain[g]),
            .chain_out(chain[g+1]),
            .status   (stat[g])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == stt_pkg::CMD_TICK) begin
                        state_next = stt_pkg::ST_SCAN;
                    end else if (s_tuser <= stt_pkg::CMD_REMOVE) begin
                        state_next = stt_pkg::ST_ACK;
                    end
                end
            end
            stt_pkg::ST_ACK: begin
                if (out_free) state_next = stt_pkg::ST_IDLE;
            end
            stt_pkg::ST_SCAN: begin
                if (last_idx && (!(cur.running && cur.expired) || out_free)) begin
                    state_next = stt_pkg::ST_WAITR;
                end
            end
            stt_pkg::ST_WAITR: begin
                if (out_free) state_next = stt_pkg::ST_IDLE;
            end
            default: state_next = stt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        ctrl           = '0;
        ctrl.now       = now_reg;
        ctrl.target    = stt_pkg::SLOT_W'(idx_reg);
        idx_next       = idx_reg;
        wait_next      = wait_reg;
        now_next       = now_reg;
        pend_slot_next = pend_slot_reg;
        pend_ok_next   = pend_ok_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        unique case (state_reg)
            stt_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                ctrl.now      = in_now;
                ctrl.target   = in_slot;
                ctrl.period   = in_period;
                ctrl.one_shot = in_once;
                ctrl.add_en   = accept && (s_tuser == stt_pkg::CMD_ADD);
                ctrl.act_en   = accept && (s_tuser == stt_pkg::CMD_ACT);
                ctrl.deact_en = accept && (s_tuser == stt_pkg::CMD_DEACT);
                ctrl.rem_en   = accept && (s_tuser == stt_pkg::CMD_REMOVE);
                now_next      = in_now;
                idx_next      = '0;
                wait_next     = max_wait_reg;
                if (s_tuser == stt_pkg::CMD_ADD) begin
                    pend_ok_next   = chain[NSLOT].found;
                    pend_slot_next = chain[NSLOT].found ? chain[NSLOT].idx : '0;
                end else begin
                    pend_ok_next   = !slot_bad;
                    pend_slot_next = '0;
                end
            end
            stt_pkg::ST_ACK: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = stt_pkg::KIND_ACK;
                    m_tdata_next  = {3'b0, 8'd0, pend_ok_reg, pend_slot_reg};
                    m_tlast_next  = 1'b1;
                end
            end
            stt_pkg::ST_SCAN: begin
                if (cur.running && cur.expired) begin
                    if (out_free) begin
                        ctrl.fire_en  = 1'b1;
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = stt_pkg::KIND_FIRE;
                        m_tdata_next  = {3'b0, 8'd0, 1'b1, stt_pkg::SLOT_W'(idx_reg)};
                        m_tlast_next  = 1'b0;
                        if (!last_idx) idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    if (cur.running && (cur.rem < {8'd0, wait_reg})) begin
                        wait_next = cur.rem[stt_pkg::WAIT_W-1:0];
                    end
                    if (!last_idx) idx_next = idx_reg + 1'b1;
                end
            end
            stt_pkg::ST_WAITR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = stt_pkg::KIND_WAIT;
                    m_tdata_next  = {3'b0, (wait_reg == '0) ? 8'd1 : wait_reg, 1'b1, 4'd0};
                    m_tlast_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stt_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            max_wait_reg <= stt_pkg::MAX_WAIT_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (psel && penable && pwrite && pready && (paddr == {stt_pkg::REG_MAX_WAIT, 2'b00})) begin
                max_wait_reg <= pwdata[stt_pkg::WAIT_W-1:0];
            end
        end
        idx_reg       <= idx_next;
        wait_reg      <= wait_next;
        now_reg       <= now_next;
        pend_slot_reg <= pend_slot_next;
        pend_ok_reg   <= pend_ok_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == {stt_pkg::REG_MAX_WAIT, 2'b00}) ? {24'd0, max_wait_reg} : 32'd0;

    a_tick_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == stt_pkg::CMD_TICK) |=> state_reg == stt_pkg::ST_SCAN)
        else $error("tick did not start scan");
    a_wait_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == stt_pkg::KIND_WAIT) |-> (m_tlast && m_tdata[12:5] != 8'd0))
        else $error("bad wait report");
    a_fire_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == stt_pkg::KIND_FIRE) |-> !m_tlast)
        else $error("fire transfer marked last");

endmodule
